### hdl/obbmtv_pkg.sv
package obbmtv_pkg;

    // number of test axes (edges a and b of each box)
    localparam int N_AX    = 4;
    localparam int SEL_W   = $clog2(N_AX);

    // operand and intermediate widths
    localparam int E_W     = 32;            // edge / center component
    localparam int D_W     = E_W + 1;       // center difference
    localparam int PR_EE_W = 2 * E_W;       // edge x edge product
    localparam int PR_ED_W = E_W + D_W;     // edge x difference product
    localparam int DEE_W   = PR_EE_W + 1;   // signed edge . edge
    localparam int DED_W   = PR_ED_W + 1;   // signed edge . difference
    localparam int LEN_W   = PR_EE_W;       // |edge . edge|
    localparam int AED_W   = PR_ED_W;       // |edge . difference|
    localparam int PEN_W   = AED_W + 1;     // summed projections, penetration
    localparam int SQ_W    = 2 * PEN_W;     // penetration squared
    localparam int X_W     = SQ_W + LEN_W;  // cross-scaled penetration
    localparam int MAG_W   = E_W;           // edge component magnitude
    localparam int NUM_W   = PEN_W + MAG_W; // push numerator
    localparam int DEN_W   = LEN_W + 1;     // push denominator
    localparam int Q_W     = 32;            // push quotient bits

    // multiplier limb size and the resulting multiplier depths
    localparam int LIMB_W  = 32;
    localparam int LAT_SQ  = ((PEN_W + LIMB_W - 1) / LIMB_W) * ((PEN_W + LIMB_W - 1) / LIMB_W);
    localparam int LAT_X   = ((SQ_W + LIMB_W - 1) / LIMB_W) * ((LEN_W + LIMB_W - 1) / LIMB_W);
    localparam int LAT_NUM = ((PEN_W + LIMB_W - 1) / LIMB_W) * ((MAG_W + LIMB_W - 1) / LIMB_W);

    // per-axis data that rides along the penetration compare
    typedef struct packed {
        logic                             sep;
        logic [N_AX-1:0]                  cneg;
        logic [N_AX-1:0][LEN_W-1:0]       len2;
        logic [N_AX-1:0][PEN_W-1:0]       pen;
        logic [N_AX-1:0][E_W-1:0]         ex;
        logic [N_AX-1:0][E_W-1:0]         ey;
    } t_geo;

    // control that rides along the push division
    typedef struct packed {
        logic             sep;
        logic             zero;
        logic             negx;
        logic             negy;
        logic             ovfx;
        logic             ovfy;
        logic [DEN_W-1:0] den;
    } t_div;

endpackage

### hdl/obbmtv_mul.sv
module obbmtv_mul #(
    parameter int A_W = 66,
    parameter int B_W = 66,
    parameter int S_W = 1
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    input  logic [S_W-1:0]     i_side,
    output logic [A_W+B_W-1:0] o_p,
    output logic [S_W-1:0]     o_side
);
    import obbmtv_pkg::*;

    localparam int NA   = (A_W + LIMB_W - 1) / LIMB_W;
    localparam int NB   = (B_W + LIMB_W - 1) / LIMB_W;
    localparam int LAT  = NA * NB;
    localparam int AP   = NA * LIMB_W;
    localparam int BP   = NB * LIMB_W;
    localparam int P_W  = A_W + B_W;
    localparam int PP_W = 2 * LIMB_W;

    logic [AP-1:0]  r_a    [LAT];
    logic [BP-1:0]  r_b    [LAT];
    logic [P_W-1:0] r_acc  [LAT];
    logic [S_W-1:0] r_side [LAT];

    logic [AP-1:0]  a_src   [LAT];
    logic [BP-1:0]  b_src   [LAT];
    logic [P_W-1:0] acc_src [LAT];
    logic [S_W-1:0] s_src   [LAT];
    logic [P_W-1:0] n_acc   [LAT];

    // one limb product per stage, added into the running sum
    always_comb begin
        a_src[0]   = AP'(i_a);
        b_src[0]   = BP'(i_b);
        acc_src[0] = '0;
        s_src[0]   = i_side;
        for (int k = 1; k < LAT; k++) begin
            a_src[k]   = r_a[k-1];
            b_src[k]   = r_b[k-1];
            acc_src[k] = r_acc[k-1];
            s_src[k]   = r_side[k-1];
        end
        for (int ia = 0; ia < NA; ia++) begin
            for (int ib = 0; ib < NB; ib++) begin
                n_acc[ia*NB+ib] = acc_src[ia*NB+ib]
                    + (P_W'(PP_W'(a_src[ia*NB+ib][ia*LIMB_W +: LIMB_W])
                          * PP_W'(b_src[ia*NB+ib][ib*LIMB_W +: LIMB_W]))
                       << ((ia + ib) * LIMB_W));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < LAT; k++) begin
                r_a[k]    <= a_src[k];
                r_b[k]    <= b_src[k];
                r_acc[k]  <= n_acc[k];
                r_side[k] <= s_src[k];
            end
        end
    end

    assign o_p    = r_acc[LAT-1];
    assign o_side = r_side[LAT-1];

endmodule

### hdl/obb_overlap_mtv_2d_core.sv
// Separating-axis overlap test of two oriented 2D boxes with minimum
// translation vector. A new box pair may be transferred on every clock while
// o_stall is low, and one result comes out per pair, in order.
// The input register loads at the transfer edge; after it come five more
// front stages of dot products, absolute values and sums, the limbed 32x32
// multipliers for the squared penetration (9) and the cross-scaled compare
// (10), axis select (2), the push numerator (3), the 33-step restoring
// divider for the push components, the sign and saturation stage (1) and the
// output register (1). An output register plus a one-entry skid buffer
// decouple the output: o_stall rises only once a result is waiting in the
// skid buffer.
module obb_overlap_mtv_2d_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [obbmtv_pkg::E_W-1:0]    i_left_center_x,
    input  logic signed [obbmtv_pkg::E_W-1:0]    i_left_center_y,
    input  logic signed [obbmtv_pkg::E_W-1:0]    i_left_edge_a_x,
    input  logic signed [obbmtv_pkg::E_W-1:0]    i_left_edge_a_y,
    input  logic signed [obbmtv_pkg::E_W-1:0]    i_left_edge_b_x,
    input  logic signed [obbmtv_pkg::E_W-1:0]    i_left_edge_b_y,
    input  logic signed [obbmtv_pkg::E_W-1:0]    i_right_center_x,
    input  logic signed [obbmtv_pkg::E_W-1:0]    i_right_center_y,
    input  logic signed [obbmtv_pkg::E_W-1:0]    i_right_edge_a_x,
    input  logic signed [obbmtv_pkg::E_W-1:0]    i_right_edge_a_y,
    input  logic signed [obbmtv_pkg::E_W-1:0]    i_right_edge_b_x,
    input  logic signed [obbmtv_pkg::E_W-1:0]    i_right_edge_b_y,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic                                 o_overlap,
    output logic signed [obbmtv_pkg::Q_W-1:0]    o_push_x,
    output logic signed [obbmtv_pkg::Q_W-1:0]    o_push_y
);
    import obbmtv_pkg::*;

    localparam int N_FRONT = 6;   // input, product, dot, abs, sum, penetration
    localparam int N_CARRY = N_FRONT - 1;
    localparam int N_ST    = N_FRONT + LAT_SQ + LAT_X + 2 + LAT_NUM + (Q_W + 1) + 1;

    localparam logic [Q_W-1:0] MIN_NEG = {1'b1, {(Q_W-1){1'b0}}};
    localparam logic [Q_W-1:0] MAX_POS = {1'b0, {(Q_W-1){1'b1}}};

    // pipeline control: whole pipe moves unless the skid buffer is full
    logic            en;
    logic [N_ST-1:0] r_v;
    logic            r_skid_v;
    logic            r_o_valid;

    assign en      = !r_skid_v;
    assign o_stall = r_skid_v;
    assign o_valid = r_o_valid;

    // ---------------- input stage: edges and center difference
    logic signed [E_W-1:0] r_ex [N_CARRY][N_AX];
    logic signed [E_W-1:0] r_ey [N_CARRY][N_AX];
    logic signed [D_W-1:0] r_dx;
    logic signed [D_W-1:0] r_dy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ex[0][0] <= i_left_edge_a_x;
            r_ey[0][0] <= i_left_edge_a_y;
            r_ex[0][1] <= i_left_edge_b_x;
            r_ey[0][1] <= i_left_edge_b_y;
            r_ex[0][2] <= i_right_edge_a_x;
            r_ey[0][2] <= i_right_edge_a_y;
            r_ex[0][3] <= i_right_edge_b_x;
            r_ey[0][3] <= i_right_edge_b_y;
            r_dx <= D_W'(i_right_center_x) - D_W'(i_left_center_x);
            r_dy <= D_W'(i_right_center_y) - D_W'(i_left_center_y);
            for (int s = 1; s < N_CARRY; s++) begin
                r_ex[s] <= r_ex[s-1];
                r_ey[s] <= r_ey[s-1];
            end
        end
    end

    // ---------------- products (upper triangle of edge pairs)
    logic signed [PR_EE_W-1:0] r_pxx [N_AX][N_AX];
    logic signed [PR_EE_W-1:0] r_pyy [N_AX][N_AX];
    logic signed [PR_ED_W-1:0] r_pdx [N_AX];
    logic signed [PR_ED_W-1:0] r_pdy [N_AX];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < N_AX; i++) begin
                for (int j = i; j < N_AX; j++) begin
                    r_pxx[i][j] <= r_ex[0][i] * r_ex[0][j];
                    r_pyy[i][j] <= r_ey[0][i] * r_ey[0][j];
                end
                r_pdx[i] <= r_ex[0][i] * r_dx;
                r_pdy[i] <= r_ey[0][i] * r_dy;
            end
        end
    end

    // ---------------- dot products
    logic signed [DEE_W-1:0] r_dee [N_AX][N_AX];
    logic signed [DED_W-1:0] r_ded [N_AX];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < N_AX; i++) begin
                for (int j = i; j < N_AX; j++) begin
                    r_dee[i][j] <= DEE_W'(r_pxx[i][j]) + DEE_W'(r_pyy[i][j]);
                end
                r_ded[i] <= DED_W'(r_pdx[i]) + DED_W'(r_pdy[i]);
            end
        end
    end

    // ---------------- magnitudes and center-projection sign
    logic [LEN_W-1:0] r_aee [N_AX][N_AX];
    logic [AED_W-1:0] r_aed [N_AX];
    logic [N_AX-1:0]  r_cneg_a;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < N_AX; i++) begin
                for (int j = i; j < N_AX; j++) begin
                    r_aee[i][j] <= r_dee[i][j][DEE_W-1] ? LEN_W'(-r_dee[i][j])
                                                         : LEN_W'(r_dee[i][j]);
                end
                r_aed[i]    <= r_ded[i][DED_W-1] ? AED_W'(-r_ded[i]) : AED_W'(r_ded[i]);
                r_cneg_a[i] <= r_ded[i][DED_W-1];
            end
        end
    end

    // ---------------- summed projections per axis
    logic [PEN_W-1:0] n_s   [N_AX];
    logic [PEN_W-1:0] r_s   [N_AX];
    logic [PEN_W-1:0] r_c2  [N_AX];
    logic [LEN_W-1:0] r_len2 [N_AX];
    logic [N_AX-1:0]  r_cneg_s;

    always_comb begin
        for (int i = 0; i < N_AX; i++) begin
            n_s[i] = '0;
            for (int j = 0; j < N_AX; j++) begin
                n_s[i] = n_s[i] + PEN_W'((j >= i) ? r_aee[i][j] : r_aee[j][i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < N_AX; i++) begin
                r_s[i]    <= n_s[i];
                r_c2[i]   <= {r_aed[i], 1'b0};
                r_len2[i] <= r_aee[i][i];
            end
            r_cneg_s <= r_cneg_a;
        end
    end

    // ---------------- separation flag and penetration
    t_geo n_geo;
    t_geo r_geo;

    always_comb begin
        n_geo.sep  = 1'b0;
        n_geo.cneg = r_cneg_s;
        for (int i = 0; i < N_AX; i++) begin
            if (r_s[i] < r_c2[i]) begin
                n_geo.sep = 1'b1;
            end
            n_geo.pen[i]  = r_s[i] - r_c2[i];
            n_geo.len2[i] = r_len2[i];
            n_geo.ex[i]   = r_ex[N_CARRY-1][i];
            n_geo.ey[i]   = r_ey[N_CARRY-1][i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_geo <= n_geo;
        end
    end

    // ---------------- penetration squared
    logic [SQ_W-1:0] sq [N_AX];
    t_geo            geo_sq;

    for (genvar i = 0; i < N_AX; i++) begin : g_sq
        if (i == 0) begin : g_side
            obbmtv_mul #(.A_W(PEN_W), .B_W(PEN_W), .S_W($bits(t_geo))) u_mul (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_a    (r_geo.pen[i]),
                .i_b    (r_geo.pen[i]),
                .i_side (r_geo),
                .o_p    (sq[i]),
                .o_side (geo_sq)
            );
        end else begin : g_plain
            obbmtv_mul #(.A_W(PEN_W), .B_W(PEN_W), .S_W(1)) u_mul (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_a    (r_geo.pen[i]),
                .i_b    (r_geo.pen[i]),
                .i_side (1'b0),
                .o_p    (sq[i]),
                .o_side ()
            );
        end
    end

    // ---------------- cross-scaled penetration: pen_i^2 * len2_k
    logic [X_W-1:0] xp [N_AX][N_AX];
    t_geo           geo_x;

    for (genvar i = 0; i < N_AX; i++) begin : g_xi
        for (genvar k = 0; k < N_AX; k++) begin : g_xk
            if (i == 0 && k == 1) begin : g_side
                obbmtv_mul #(.A_W(SQ_W), .B_W(LEN_W), .S_W($bits(t_geo))) u_mul (
                    .i_clk  (i_clk),
                    .i_en   (en),
                    .i_a    (sq[i]),
                    .i_b    (geo_sq.len2[k]),
                    .i_side (geo_sq),
                    .o_p    (xp[i][k]),
                    .o_side (geo_x)
                );
            end else if (i != k) begin : g_plain
                obbmtv_mul #(.A_W(SQ_W), .B_W(LEN_W), .S_W(1)) u_mul (
                    .i_clk  (i_clk),
                    .i_en   (en),
                    .i_a    (sq[i]),
                    .i_b    (geo_sq.len2[k]),
                    .i_side (1'b0),
                    .o_p    (xp[i][k]),
                    .o_side ()
                );
            end
        end
    end

    // ---------------- pairwise "axis i penetrates less than axis k" (k < i)
    logic [N_AX-1:0][N_AX-1:0] n_lt;
    logic [N_AX-1:0][N_AX-1:0] r_lt;
    t_geo                      r_geo_c;

    always_comb begin
        n_lt = '0;
        for (int i = 1; i < N_AX; i++) begin
            for (int k = 0; k < i; k++) begin
                if (geo_x.len2[k] == '0) begin
                    n_lt[i][k] = 1'b0;
                end else if (geo_x.len2[i] == '0) begin
                    n_lt[i][k] = (geo_x.pen[k] != '0);
                end else begin
                    n_lt[i][k] = (xp[i][k] < xp[k][i]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lt    <= n_lt;
            r_geo_c <= geo_x;
        end
    end

    // ---------------- axis select, first axis wins ties
    logic [SEL_W-1:0] sel;
    logic [E_W-1:0]   sel_ex;
    logic [E_W-1:0]   sel_ey;
    logic [LEN_W-1:0] sel_len2;
    t_div             n_dsel;
    logic [PEN_W-1:0] r_pen_s;
    logic [MAG_W-1:0] r_magx;
    logic [MAG_W-1:0] r_magy;
    t_div             r_dsel;

    always_comb begin
        sel = '0;
        for (int i = 1; i < N_AX; i++) begin
            if (r_lt[i][sel]) begin
                sel = SEL_W'(i);
            end
        end
        sel_ex        = r_geo_c.ex[sel];
        sel_ey        = r_geo_c.ey[sel];
        sel_len2      = r_geo_c.len2[sel];
        n_dsel.sep    = r_geo_c.sep;
        n_dsel.zero   = (sel_len2 == '0);
        n_dsel.negx   = sel_ex[E_W-1] != r_geo_c.cneg[sel];
        n_dsel.negy   = sel_ey[E_W-1] != r_geo_c.cneg[sel];
        n_dsel.ovfx   = 1'b0;
        n_dsel.ovfy   = 1'b0;
        n_dsel.den    = {sel_len2, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pen_s <= r_geo_c.pen[sel];
            r_magx  <= sel_ex[E_W-1] ? MAG_W'(-sel_ex) : sel_ex;
            r_magy  <= sel_ey[E_W-1] ? MAG_W'(-sel_ey) : sel_ey;
            r_dsel  <= n_dsel;
        end
    end

    // ---------------- push numerators: pen * |e|
    logic [NUM_W-1:0] numx;
    logic [NUM_W-1:0] numy;
    t_div             dv_num;

    obbmtv_mul #(.A_W(PEN_W), .B_W(MAG_W), .S_W($bits(t_div))) u_numx (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_a    (r_pen_s),
        .i_b    (r_magx),
        .i_side (r_dsel),
        .o_p    (numx),
        .o_side (dv_num)
    );

    obbmtv_mul #(.A_W(PEN_W), .B_W(MAG_W), .S_W(1)) u_numy (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_a    (r_pen_s),
        .i_b    (r_magy),
        .i_side (1'b0),
        .o_p    (numy),
        .o_side ()
    );

    // ---------------- restoring divide, overflow check then one bit a stage
    logic [NUM_W-1:0] n_remx [Q_W+1];
    logic [NUM_W-1:0] n_remy [Q_W+1];
    logic [Q_W-1:0]   n_qx   [Q_W+1];
    logic [Q_W-1:0]   n_qy   [Q_W+1];
    t_div             n_dv   [Q_W+1];
    logic [NUM_W-1:0] r_remx [Q_W+1];
    logic [NUM_W-1:0] r_remy [Q_W+1];
    logic [Q_W-1:0]   r_qx   [Q_W+1];
    logic [Q_W-1:0]   r_qy   [Q_W+1];
    t_div             r_dv   [Q_W+1];

    always_comb begin
        n_remx[0]   = numx;
        n_remy[0]   = numy;
        n_qx[0]     = '0;
        n_qy[0]     = '0;
        n_dv[0]     = dv_num;
        n_dv[0].ovfx = numx >= (NUM_W'(dv_num.den) << Q_W);
        n_dv[0].ovfy = numy >= (NUM_W'(dv_num.den) << Q_W);
        for (int j = 1; j <= Q_W; j++) begin
            n_remx[j] = r_remx[j-1];
            n_remy[j] = r_remy[j-1];
            n_qx[j]   = r_qx[j-1];
            n_qy[j]   = r_qy[j-1];
            n_dv[j]   = r_dv[j-1];
            if (r_remx[j-1] >= (NUM_W'(r_dv[j-1].den) << (Q_W - j))) begin
                n_remx[j]          = r_remx[j-1] - (NUM_W'(r_dv[j-1].den) << (Q_W - j));
                n_qx[j][Q_W - j]   = 1'b1;
            end
            if (r_remy[j-1] >= (NUM_W'(r_dv[j-1].den) << (Q_W - j))) begin
                n_remy[j]          = r_remy[j-1] - (NUM_W'(r_dv[j-1].den) << (Q_W - j));
                n_qy[j][Q_W - j]   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j <= Q_W; j++) begin
                r_remx[j] <= n_remx[j];
                r_remy[j] <= n_remy[j];
                r_qx[j]   <= n_qx[j];
                r_qy[j]   <= n_qy[j];
                r_dv[j]   <= n_dv[j];
            end
        end
    end

    // ---------------- sign and saturation
    function automatic logic [Q_W-1:0] push_val(input logic [Q_W-1:0] q, input logic ovf,
                                                 input logic neg, input logic kill);
        logic [Q_W-1:0] res;
        if (kill) begin
            res = '0;
        end else if (neg) begin
            res = (ovf || q > MIN_NEG) ? MIN_NEG : -q;
        end else begin
            res = (ovf || q[Q_W-1]) ? MAX_POS : q;
        end
        return res;
    endfunction

    logic           r_p_ovl;
    logic [Q_W-1:0] r_p_px;
    logic [Q_W-1:0] r_p_py;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_ovl <= !r_dv[Q_W].sep;
            r_p_px  <= push_val(r_qx[Q_W], r_dv[Q_W].ovfx, r_dv[Q_W].negx,
                                r_dv[Q_W].sep || r_dv[Q_W].zero);
            r_p_py  <= push_val(r_qy[Q_W], r_dv[Q_W].ovfy, r_dv[Q_W].negy,
                                r_dv[Q_W].sep || r_dv[Q_W].zero);
        end
    end

    // ---------------- valid bits, output register and skid buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v       <= '0;
            r_o_valid <= 1'b0;
            r_skid_v  <= 1'b0;
        end else begin
            if (en) begin
                r_v <= {r_v[N_ST-2:0], i_valid};
            end
            if (r_skid_v) begin
                if (!r_o_valid || !i_stall) begin
                    r_o_valid <= 1'b1;
                    r_skid_v  <= 1'b0;
                end
            end else if (!r_o_valid || !i_stall) begin
                r_o_valid <= r_v[N_ST-1];
            end else if (r_v[N_ST-1]) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    logic           r_k_ovl;
    logic [Q_W-1:0] r_k_px;
    logic [Q_W-1:0] r_k_py;
    logic           r_o_ovl;
    logic [Q_W-1:0] r_o_px;
    logic [Q_W-1:0] r_o_py;

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (!r_o_valid || !i_stall) begin
                r_o_ovl <= r_k_ovl;
                r_o_px  <= r_k_px;
                r_o_py  <= r_k_py;
            end
        end else if (!r_o_valid || !i_stall) begin
            r_o_ovl <= r_p_ovl;
            r_o_px  <= r_p_px;
            r_o_py  <= r_p_py;
        end else begin
            r_k_ovl <= r_p_ovl;
            r_k_px  <= r_p_px;
            r_k_py  <= r_p_py;
        end
    end

    assign o_overlap = r_o_ovl;
    assign o_push_x  = r_o_px;
    assign o_push_y  = r_o_py;

endmodule

### bench/obb_overlap_mtv_2d_core_test.sv
`timescale 1ns / 1ps

module obb_overlap_mtv_2d_core_test;

    import obbmtv_pkg::*;

    typedef logic signed [E_W-1:0] t_word;
    typedef logic [255:0] t_wide;

    // one expected contact result
    typedef struct {
        bit          overlap;
        logic [31:0] push_x;
        logic [31:0] push_y;
    } t_contact;

    // predicts the separating-axis contact and holds results in flight
    class mtv_scoreboard;
        t_contact pending[$];
        int       errors = 0;

        static function t_wide abs_dot(logic signed [127:0] ax, logic signed [127:0] ay,
                                       logic signed [127:0] bx, logic signed [127:0] by,
                                       output bit neg);
            logic signed [127:0] dt;
            dt  = ax * bx + ay * by;
            neg = dt < 0;
            return t_wide'(neg ? -dt : dt);
        endfunction

        // truncated push component with saturation
        static function logic [31:0] push_comp(t_wide pen, t_wide len2, bit cneg,
                                               logic signed [127:0] e);
            t_wide q;
            bit    neg;
            if (len2 == 0) return 32'd0;
            q = (pen * t_wide'(e < 0 ? -e : e)) / (len2 + len2);
            if (q == 0) return 32'd0;
            neg = (e < 0) != cneg;
            if (neg) begin
                if (q > 256'h8000_0000) q = 256'h8000_0000;
                return -q[31:0];
            end
            if (q > 256'h7FFF_FFFF) q = 256'h7FFF_FFFF;
            return q[31:0];
        endfunction

        static function t_contact predict(t_word v[12]);
            logic signed [127:0] ex[4], ey[4], dx, dy, l0, l1, r0, r1;
            t_wide    len2[4], pen[4], s, c, t, a, b;
            bit       cn[4], ng;
            int       sel;
            t_contact r;
            l0 = v[0]; l1 = v[1]; r0 = v[6]; r1 = v[7];
            dx = r0 - l0;
            dy = r1 - l1;
            ex[0] = v[2];  ey[0] = v[3];
            ex[1] = v[4];  ey[1] = v[5];
            ex[2] = v[8];  ey[2] = v[9];
            ex[3] = v[10]; ey[3] = v[11];
            r = '{1'b0, 32'd0, 32'd0};
            for (int i = 0; i < N_AX; i++) begin
                s = 0;
                for (int j = 0; j < N_AX; j++) begin
                    t = abs_dot(ex[i], ey[i], ex[j], ey[j], ng);
                    s += t;
                    if (j == i) len2[i] = t;
                end
                c = abs_dot(ex[i], ey[i], dx, dy, cn[i]);
                if (s < c + c) return r;
                pen[i] = s - c - c;
            end
            // smallest penetration per unit length, earliest axis on ties
            sel = 0;
            for (int i = 1; i < N_AX; i++) begin
                if (len2[sel] == 0) continue;
                if (len2[i] == 0) begin
                    if (pen[sel] != 0) sel = i;
                    continue;
                end
                a = pen[i] * pen[i] * len2[sel];
                b = pen[sel] * pen[sel] * len2[i];
                if (a < b) sel = i;
            end
            r.overlap = 1'b1;
            r.push_x  = push_comp(pen[sel], len2[sel], cn[sel], ex[sel]);
            r.push_y  = push_comp(pen[sel], len2[sel], cn[sel], ey[sel]);
            return r;
        endfunction

        function void note_pair(t_word v[12]);
            pending.push_back(predict(v));
        endfunction

        function void check_result(bit ov, logic [31:0] px, logic [31:0] py);
            t_contact e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result ov=%0b px=%h py=%h", $time, ov, px, py);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (ov !== e.overlap) begin
                $display("%0t: overlap exp %0b got %0b", $time, e.overlap, ov);
                errors++;
            end
            if (px !== e.push_x) begin
                $display("%0t: push_x exp %h got %h", $time, e.push_x, px);
                errors++;
            end
            if (py !== e.push_y) begin
                $display("%0t: push_y exp %h got %h", $time, e.push_y, py);
                errors++;
            end
        endfunction
    endclass

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  i_stall = 1'b0;
    t_word fld[12];
    logic  o_stall, o_valid, o_overlap;
    logic signed [Q_W-1:0] o_push_x, o_push_y;

    int snd_idle = 29;
    int rcv_idle = 54;
    mtv_scoreboard board = new();

    obb_overlap_mtv_2d_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_left_center_x(fld[0]), .i_left_center_y(fld[1]),
        .i_left_edge_a_x(fld[2]), .i_left_edge_a_y(fld[3]),
        .i_left_edge_b_x(fld[4]), .i_left_edge_b_y(fld[5]),
        .i_right_center_x(fld[6]), .i_right_center_y(fld[7]),
        .i_right_edge_a_x(fld[8]), .i_right_edge_a_y(fld[9]),
        .i_right_edge_b_x(fld[10]), .i_right_edge_b_y(fld[11]),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_overlap(o_overlap), .o_push_x(o_push_x), .o_push_y(o_push_y)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        foreach (fld[k]) fld[k] = '0;
    end

    // receive side: random stall, check every transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_result(o_overlap, o_push_x, o_push_y);
        i_stall <= ($urandom_range(99) < rcv_idle);
    end

    // one box pair transfer, with random idle cycles ahead of it
    task automatic send_pair(t_word v[12]);
        if ($urandom_range(99) < snd_idle) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < snd_idle);
        end
        i_valid <= 1'b1;
        foreach (v[k]) fld[k] <= v[k];
        do @(posedge i_clk); while (o_stall);
        board.note_pair(v);
    endtask

    task automatic send_box(t_word lcx, t_word lcy, t_word lax, t_word lay, t_word lbx,
                            t_word lby, t_word rcx, t_word rcy, t_word rax, t_word ray,
                            t_word rbx, t_word rby);
        t_word v[12];
        v = '{lcx, lcy, lax, lay, lbx, lby, rcx, rcy, rax, ray, rbx, rby};
        send_pair(v);
    endtask

    function automatic t_word pick_word(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
            default: begin
                case ($urandom_range(4))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0;
                    3: return -32'sd1;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    // mostly nearby boxes with random rotation so contacts are common
    task automatic send_random();
        t_word v[12];
        int    mode;
        mode = $urandom_range(9);
        if (mode < 6) begin
            foreach (v[k]) v[k] = pick_word(1);
            if ($urandom_range(3) == 0) begin
                // perpendicular edges, axis-aligned-like rectangles
                v[4] = -v[3];  v[5] = v[2];
                v[10] = -v[9]; v[11] = v[8];
            end
            if ($urandom_range(7) == 0) v[8 + 2 * $urandom_range(1)] = 0;
        end else begin
            foreach (v[k]) v[k] = pick_word(mode < 9 ? 0 : 2);
        end
        if ($urandom_range(15) == 0) begin
            v[2 + $urandom_range(1) * 2] = 0;
            v[3] = 0;
        end
        send_pair(v);
    endtask

    initial begin
        t_word mn, mx, one;
        mn  = 32'h8000_0000;
        mx  = 32'h7FFF_FFFF;
        one = 32'h0001_0000;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: degenerate, touching, separated, extremes
        send_box(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_box(0, 0, 2*one, 0, 0, 2*one, 2*one, 0, 2*one, 0, 0, 2*one);
        send_box(0, 0, 2*one, 0, 0, 2*one, 2*one+1, 0, 2*one, 0, 0, 2*one);
        send_box(0, 0, 2*one, 0, 0, 2*one, one, one/2, 2*one, 0, 0, 2*one);
        send_box(0, 0, 2*one, 0, 0, 2*one, -one, -one/2, 2*one, 0, 0, 2*one);
        send_box(0, 0, 2*one, 2*one, -one, one, one/4, 0, one, 0, 0, one);
        send_box(0, 0, 0, 0, 0, 2*one, one, 0, 2*one, 0, 0, 2*one);
        send_box(0, 0, 2*one, 0, 0, 0, 0, one, 2*one, 0, 0, 2*one);
        send_box(mn, mn, mx, mx, mn, mx, mx, mx, mn, mn, mx, mn);
        send_box(mx, mx, mn, mn, mn, mn, mn, mn, mx, mx, mx, mx);
        send_box(0, 0, mn, 0, 0, mn, 1, 0, mn, 0, 0, mn);
        send_box(0, 0, mx, 0, 0, mx, -1, 1, mx, 0, 0, mx);
        send_box(0, 0, mx, mx, mn, mx, 0, 0, mx, mn, mx, mx);
        send_box(mn, mx, 1, 0, 0, 1, mx, mn, 1, 0, 0, 1);
        send_box(0, 0, -1, -1, -1, -1, 0, 0, -1, -1, -1, -1);
        send_box(5, -7, 3, 4, -4, 3, 6, -6, 1, 0, 0, 1);

        for (int n = 0; n < 350; n++) send_random();
        snd_idle = 54; rcv_idle = 29;
        for (int n = 0; n < 350; n++) send_random();
        snd_idle = 0; rcv_idle = 0;
        for (int n = 0; n < 350; n++) send_random();
        i_valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (board.errors == 0)
            $display("obb_overlap_mtv_2d_core_test: clean");
        else
            $display("obb_overlap_mtv_2d_core_test: errors");
        $finish;
    end

    // run limit
    initial begin
        #5ms;
        $display("obb_overlap_mtv_2d_core_test: errors");
        $finish;
    end

endmodule
